// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the boot information parser checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define BITP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BITP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bitp_pkg.sv
// ----------------------------------------------------------------------------
// Boot information parser package
// Record codes, status codes, tag kinds and the summary record bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bitp_pkg;

   localparam logic [32:0] WORD_BYTES      = 33'd8;
   localparam logic [31:0] MIN_TAG_BYTES   = 32'd8;
   localparam logic [31:0] MIN_ENTRY_BYTES = 32'd24;
   localparam logic [31:0] MMAP_AVAILABLE  = 32'd1;

   // Tag kinds that the walker decodes.
   localparam logic [31:0] TAG_END         = 32'd0;
   localparam logic [31:0] TAG_CMDLINE     = 32'd1;
   localparam logic [31:0] TAG_LOADER_NAME = 32'd2;
   localparam logic [31:0] TAG_BASIC_MEM   = 32'd4;
   localparam logic [31:0] TAG_MMAP        = 32'd6;
   localparam logic [31:0] TAG_FRAMEBUFFER = 32'd8;

   typedef enum logic [3:0] {
      REC_STATUS      = 4'd0,
      REC_TAGS        = 4'd1,
      REC_FB_PRESENT  = 4'd2,
      REC_FB_ADDR     = 4'd3,
      REC_PITCH       = 4'd4,
      REC_WIDTH       = 4'd5,
      REC_HEIGHT      = 4'd6,
      REC_BPP         = 4'd7,
      REC_MEM_PRESENT = 4'd8,
      REC_MEM_LOWER   = 4'd9,
      REC_MEM_UPPER   = 4'd10,
      REC_MMAP_COUNT  = 4'd11,
      REC_MMAP_AVAIL  = 4'd12,
      REC_LOADER_OFF  = 4'd13,
      REC_CMDLINE_OFF = 4'd14
   } record_id_type;

   typedef enum logic [1:0] {
      STATUS_END_TAG      = 2'd0,
      STATUS_SIZE_REACHED = 2'd1,
      STATUS_MALFORMED    = 2'd2
   } walk_status_type;

   typedef struct packed {
      walk_status_type status;
      logic [31:0]     tags;
      logic            fb_found;
      logic [63:0]     fb_addr;
      logic [31:0]     pitch;
      logic [31:0]     width;
      logic [31:0]     height;
      logic [7:0]      bpp;
      logic            mem_present;
      logic [31:0]     low_mem;
      logic [31:0]     high_mem;
      logic [31:0]     map_count;
      logic [63:0]     map_avail;
      logic [31:0]     loader_off;
      logic [31:0]     cmdline_off;
   } summary_type;

endpackage

`default_nettype wire

// File: rtl/bitp_req_if.sv
// ----------------------------------------------------------------------------
// Structure word channel
// Valid/ready channel that carries one 64-bit structure word per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bitp_req_if;
   logic        valid;
   logic        ready;
   logic        first_word;
   logic [63:0] info_word;

   modport source (output valid, output first_word, output info_word, input ready);
   modport sink   (input valid, input first_word, input info_word, output ready);
endinterface

`default_nettype wire

// File: rtl/bitp_rsp_if.sv
// ----------------------------------------------------------------------------
// Summary record channel
// Valid/ready channel that carries one summary record per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bitp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  record_id;
   logic [63:0] record_value;
   logic        last_record;

   modport source (output valid, output record_id, output record_value,
                   output last_record, input ready);
   modport sink   (input valid, input record_id, input record_value,
                   input last_record, output ready);
endinterface

`default_nettype wire

// File: rtl/bitp_walker.sv
// ----------------------------------------------------------------------------
// Tag walker
// Holds the walk state and decodes one structure word per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bitp_walker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  logic                 item_first,
   input  logic [63:0]          item_word,
   input  logic                 item_take,
   output logic                 item_done,
   output bitp_pkg::summary_type summary
);
   import bitp_pkg::*;

   typedef struct packed {
      logic        active;
      logic [31:0] byte_offset;
      logic [31:0] total_bytes;
      logic [31:0] tag_base;
      logic [31:0] tag_kind;
      logic [31:0] tag_bytes;
      logic [31:0] tags_seen;
      logic [31:0] entry_bytes;
      logic [28:0] entry_pos;
      logic [63:0] pending_len;
      logic [31:0] map_count;
      logic [63:0] map_avail;
      logic [63:0] fb_addr;
      logic [31:0] pitch;
      logic [31:0] width;
      logic [31:0] height;
      logic [7:0]  bpp;
      logic [31:0] low_mem;
      logic [31:0] high_mem;
      logic [31:0] loader_off;
      logic [31:0] cmdline_off;
      logic        fb_found;
      logic        mem_present;
   } walk_state_type;

   walk_state_type  state_ff;
   walk_state_type  state_in;
   walk_status_type status;
   logic            finish;
   logic            head_stop;
   logic [31:0]     lo;
   logic [31:0]     hi;
   logic [31:0]     diff;
   logic [28:0]     k;
   logic [32:0]     next_off;
   logic [32:0]     rounded;
   logic [28:0]     last_pos;
   logic [63:0]     pend;
   logic            entry_fits;

   assign lo       = item_word[31:0];
   assign hi       = item_word[63:32];
   assign diff     = state_ff.byte_offset - state_ff.tag_base;
   assign k        = diff[31:3];
   assign next_off = {1'b0, state_ff.byte_offset} + WORD_BYTES;
   assign last_pos = state_ff.entry_bytes[31:3] - 29'd1;
   assign entry_fits = ({1'b0, diff} + WORD_BYTES) <= {1'b0, state_ff.tag_bytes};

   always_comb begin
      state_in  = state_ff;
      status    = STATUS_SIZE_REACHED;
      finish    = 1'b0;
      head_stop = 1'b0;
      rounded   = '0;
      pend      = state_ff.pending_len;
      if (item_first) begin
         state_in             = '0;
         state_in.total_bytes = lo;
         state_in.byte_offset = WORD_BYTES[31:0];
         state_in.tag_base    = WORD_BYTES[31:0];
         state_in.active      = 1'b1;
         if (lo <= WORD_BYTES[31:0]) begin
            finish = 1'b1;
         end
      end else if (state_ff.active) begin
         if (k == '0) begin
            // Tag header word: type in the low half, size in the high half.
            state_in.tag_kind  = lo;
            state_in.tag_bytes = hi;
            state_in.tags_seen = state_ff.tags_seen + 32'd1;
            if (lo == TAG_END) begin
               finish    = 1'b1;
               status    = STATUS_END_TAG;
               head_stop = 1'b1;
            end else if (hi < MIN_TAG_BYTES) begin
               finish    = 1'b1;
               status    = STATUS_MALFORMED;
               head_stop = 1'b1;
            end else begin
               state_in.entry_bytes = '0;
               state_in.entry_pos   = '0;
               state_in.pending_len = '0;
               if (lo == TAG_CMDLINE) begin
                  state_in.cmdline_off = state_ff.tag_base + WORD_BYTES[31:0];
               end
               if (lo == TAG_LOADER_NAME) begin
                  state_in.loader_off = state_ff.tag_base + WORD_BYTES[31:0];
               end
               if (lo == TAG_BASIC_MEM) begin
                  state_in.mem_present = 1'b1;
                  state_in.low_mem     = '0;
                  state_in.high_mem    = '0;
               end
               if (lo == TAG_MMAP) begin
                  state_in.map_count = '0;
                  state_in.map_avail = '0;
               end
               if (lo == TAG_FRAMEBUFFER) begin
                  state_in.fb_found   = 1'b1;
                  state_in.fb_addr    = '0;
                  state_in.pitch      = '0;
                  state_in.width      = '0;
                  state_in.height     = '0;
                  state_in.bpp        = '0;
               end
            end
         end else begin
            // Body word: a field is taken only when it lies wholly inside the tag.
            if (state_ff.tag_kind == TAG_BASIC_MEM) begin
               if (k == 29'd1) begin
                  if (state_ff.tag_bytes >= 32'd12) state_in.low_mem = lo;
                  if (state_ff.tag_bytes >= 32'd16) state_in.high_mem = hi;
               end
            end else if (state_ff.tag_kind == TAG_FRAMEBUFFER) begin
               if (k == 29'd1 && state_ff.tag_bytes >= 32'd16) state_in.fb_addr = item_word;
               if (k == 29'd2) begin
                  if (state_ff.tag_bytes >= 32'd20) state_in.pitch = lo;
                  if (state_ff.tag_bytes >= 32'd24) state_in.width = hi;
               end
               if (k == 29'd3) begin
                  if (state_ff.tag_bytes >= 32'd28) state_in.height = lo;
                  if (state_ff.tag_bytes >= 32'd29) state_in.bpp = hi[7:0];
               end
            end else if (state_ff.tag_kind == TAG_MMAP) begin
               if (k == 29'd1) begin
                  state_in.entry_bytes = '0;
                  if (state_ff.tag_bytes >= 32'd12 && lo[2:0] == 3'd0 &&
                      lo >= MIN_ENTRY_BYTES) begin
                     state_in.entry_bytes = lo;
                  end
                  state_in.entry_pos   = '0;
                  state_in.pending_len = '0;
               end else if (state_ff.entry_bytes != '0) begin
                  // Second entry word is the length, third holds the type.
                  if (state_ff.entry_pos == 29'd1) pend = item_word;
                  if (state_ff.entry_pos == 29'd2 && lo != MMAP_AVAILABLE) pend = '0;
                  state_in.pending_len = pend;
                  if (state_ff.entry_pos == last_pos) begin
                     if (entry_fits) begin
                        state_in.map_count = state_ff.map_count + 32'd1;
                        state_in.map_avail = state_ff.map_avail + pend;
                     end
                     state_in.entry_pos   = '0;
                     state_in.pending_len = '0;
                  end else begin
                     state_in.entry_pos = state_ff.entry_pos + 29'd1;
                  end
               end
            end
         end
         if (!head_stop) begin
            rounded = ({1'b0, state_in.tag_bytes} + 33'd7) & ~33'd7;
            if (next_off[32]) begin
               finish = 1'b1;
            end else if ((next_off - {1'b0, state_ff.tag_base}) >= rounded) begin
               if (next_off >= {1'b0, state_ff.total_bytes}) begin
                  finish = 1'b1;
               end else begin
                  state_in.tag_base    = next_off[31:0];
                  state_in.byte_offset = next_off[31:0];
               end
            end else begin
               state_in.byte_offset = next_off[31:0];
            end
         end
      end
      if (finish) begin
         state_in.active = 1'b0;
      end
   end

   assign item_done = item_valid && finish;

   always_comb begin
      summary.status      = status;
      summary.tags        = state_in.tags_seen;
      summary.fb_found    = state_in.fb_found;
      summary.fb_addr     = state_in.fb_addr;
      summary.pitch       = state_in.pitch;
      summary.width       = state_in.width;
      summary.height      = state_in.height;
      summary.bpp         = state_in.bpp;
      summary.mem_present = state_in.mem_present;
      summary.low_mem     = state_in.low_mem;
      summary.high_mem    = state_in.high_mem;
      summary.map_count   = state_in.map_count;
      summary.map_avail   = state_in.map_avail;
      summary.loader_off  = state_in.loader_off;
      summary.cmdline_off = state_in.cmdline_off;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (item_take) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bitp_summary.sv
// ----------------------------------------------------------------------------
// Summary emitter
// Holds a finished walk's summary and sends it as fifteen records.
// ----------------------------------------------------------------------------
`default_nettype none

module bitp_summary (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  bitp_pkg::summary_type summary,
   output logic                  free,
   bitp_rsp_if.source            rsp_chan
);
   import bitp_pkg::*;

   summary_type   snap_ff;
   logic          busy_ff;
   record_id_type idx_ff;
   logic          is_last;
   logic          taken;

   assign is_last = (idx_ff == REC_CMDLINE_OFF);
   assign taken   = busy_ff && rsp_chan.ready;
   assign free    = !busy_ff || (rsp_chan.ready && is_last);

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.record_id   = idx_ff;
   assign rsp_chan.last_record = is_last;

   always_comb begin
      unique case (idx_ff)
         REC_STATUS:      rsp_chan.record_value = {62'd0, snap_ff.status};
         REC_TAGS:        rsp_chan.record_value = {32'd0, snap_ff.tags};
         REC_FB_PRESENT:  rsp_chan.record_value = {63'd0, snap_ff.fb_found};
         REC_FB_ADDR:     rsp_chan.record_value = snap_ff.fb_addr;
         REC_PITCH:       rsp_chan.record_value = {32'd0, snap_ff.pitch};
         REC_WIDTH:       rsp_chan.record_value = {32'd0, snap_ff.width};
         REC_HEIGHT:      rsp_chan.record_value = {32'd0, snap_ff.height};
         REC_BPP:         rsp_chan.record_value = {56'd0, snap_ff.bpp};
         REC_MEM_PRESENT: rsp_chan.record_value = {63'd0, snap_ff.mem_present};
         REC_MEM_LOWER:   rsp_chan.record_value = {32'd0, snap_ff.low_mem};
         REC_MEM_UPPER:   rsp_chan.record_value = {32'd0, snap_ff.high_mem};
         REC_MMAP_COUNT:  rsp_chan.record_value = {32'd0, snap_ff.map_count};
         REC_MMAP_AVAIL:  rsp_chan.record_value = snap_ff.map_avail;
         REC_LOADER_OFF:  rsp_chan.record_value = {32'd0, snap_ff.loader_off};
         REC_CMDLINE_OFF: rsp_chan.record_value = {32'd0, snap_ff.cmdline_off};
         default:         rsp_chan.record_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= REC_STATUS;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= REC_STATUS;
      end else if (taken) begin
         if (is_last) begin
            busy_ff <= 1'b0;
            idx_ff  <= REC_STATUS;
         end else begin
            idx_ff <= record_id_type'(idx_ff + 4'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         snap_ff <= summary;
      end
   end

endmodule

`default_nettype wire

// File: rtl/boot_info_tag_parser_top.sv
// ----------------------------------------------------------------------------
// Boot information tag parser
// Walks a streamed boot information structure and reports a summary.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Payload                                  Per transaction
//   req_chan   in         first_word, info_word                    one 64-bit word
//   rsp_chan   out        record_id, record_value, last_record     one record
//
// One structure word is accepted per cycle unless a held word must wait. The
// walker decodes each word while it sits in the input register, and the walk
// state takes the result at the next edge; the first record of a summary is
// offered right after. A word that ends the walk loads a fifteen-record summary
// that the summary register sends one record per cycle while rsp_chan is ready;
// words that end no walk keep flowing meanwhile. A word that would end a walk
// waits in the input register until the prior summary's last record is taken.
// Reset is synchronous and clears the walk, the input register and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module boot_info_tag_parser_top (
   input  logic      clock,
   input  logic      reset,
   bitp_req_if.sink  req_chan,
   bitp_rsp_if.source rsp_chan
);
   import bitp_pkg::*;

   // Input register: holds the word that the walker decodes this cycle.
   logic        in_valid_ff;
   logic        in_first_ff;
   logic [63:0] in_word_ff;

   logic        take;
   logic        done;
   logic        snap_free;
   summary_type summary;

   // The held word moves into the walker unless it would end a walk while the
   // emitter still owns a summary whose final record is not being taken.
   assign take = in_valid_ff && (!done || snap_free);
   assign req_chan.ready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_first_ff <= req_chan.first_word;
         in_word_ff  <= req_chan.info_word;
      end
   end

   bitp_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item_first (in_first_ff),
      .item_word  (in_word_ff),
      .item_take  (take),
      .item_done  (done),
      .summary    (summary)
   );

   bitp_summary u_summary (
      .clock    (clock),
      .reset    (reset),
      .load     (take && done),
      .summary  (summary),
      .free     (snap_free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// File: rtl/bitp_checker.sv
// ----------------------------------------------------------------------------
// Boot information parser checker
// Port-level checks on the summary record sequence.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bitp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_record_id,
   input logic       rsp_last_record
);
   import bitp_pkg::*;

   `BITP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "record dropped while stalled")

   `BITP_ASSERT(a_rsp_next_id, clock, reset, rsp_valid && rsp_ready && !rsp_last_record |=> rsp_valid && rsp_record_id == 4'($past(rsp_record_id) + 4'd1), "records out of sequence")

   `BITP_ASSERT(a_rsp_last_id, clock, reset, rsp_valid |-> (rsp_last_record == (rsp_record_id == REC_CMDLINE_OFF)), "last flag on wrong record")

   `BITP_ASSERT(a_rsp_restart, clock, reset, rsp_valid && rsp_ready && rsp_last_record |=> !rsp_valid || rsp_record_id == REC_STATUS, "summary does not start at status")

   `BITP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "records pending after reset")

endmodule

bind boot_info_tag_parser_top bitp_checker u_bitp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_record_id   (rsp_chan.record_id),
   .rsp_last_record (rsp_chan.last_record)
);

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Boot information tag parser testbench
// Streams boot information structures into the parser, predicts the fifteen
// summary records of every finished walk, and checks each record in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bitp_pkg::*;

   localparam int unsigned RANDOM_WORDS  = 460;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned LIMIT_CYCLES  = 600000;

   // One structure word waiting to be sent. A word marked hold_back is not
   // offered until every predicted record has been received.
   typedef struct {
      bit          first;
      logic [63:0] data;
      bit          hold_back;
   } word_item_type;

   typedef struct {
      record_id_type id;
      logic [63:0]   value;
      logic          is_last;
   } summary_rec_type;

   // Clock, reset and the stimulus side of both channels. The channel inputs
   // come from plain variables so that each has a single procedural driver
   // and a known value from time zero.
   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        word_valid   = 1'b0;
   logic        word_first   = 1'b0;
   logic [63:0] word_data    = '0;
   logic        record_ready = 1'b0;

   bitp_req_if req_bus ();
   bitp_rsp_if rsp_bus ();

   assign req_bus.valid      = word_valid;
   assign req_bus.first_word = word_first;
   assign req_bus.info_word  = word_data;
   assign rsp_bus.ready      = record_ready;

   boot_info_tag_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   // Words still to be offered, and the records that the walk predicts.
   word_item_type   words_to_send[$];
   summary_rec_type expected_records[$];
   int unsigned  words_counted   = 0;
   int unsigned  structures_made = 0;
   int unsigned  error_count     = 0;
   int unsigned  cycle_count     = 0;

   // Byte images used while a structure is being assembled.
   logic [7:0] image_bytes[$];
   logic [7:0] tag_body[$];

   // Handshake bookkeeping shared by the driver, the receiver and the monitor.
   bit          word_taken  = 1'b0;
   bit          rsp_taken   = 1'b0;
   bit          word_quiet  = 1'b0;
   bit          rsp_quiet   = 1'b0;
   int unsigned word_wait   = 0;
   int unsigned rsp_wait    = 0;

   // ------------------------------------------------------------------------
   // Walk state of the predictor. It mirrors what the parser must remember
   // between words: where the walk is, the current tag and every captured
   // field that ends up in the summary.
   // ------------------------------------------------------------------------
   bit          walking     = 1'b0;
   logic [31:0] word_ofs    = '0;
   logic [31:0] struct_size = '0;
   logic [31:0] tag_start   = '0;
   logic [31:0] cur_kind    = '0;
   logic [31:0] cur_bytes   = '0;
   logic [31:0] tags_total  = '0;
   logic [31:0] ent_size    = '0;
   logic [31:0] ent_pos     = '0;
   logic [63:0] pend_len    = '0;
   logic [31:0] map_count   = '0;
   logic [63:0] map_sum     = '0;
   logic [63:0] fb_addr     = '0;
   logic [31:0] fb_stride   = '0;
   logic [31:0] fb_cols     = '0;
   logic [31:0] fb_rows     = '0;
   logic [7:0]  fb_bpp      = '0;
   logic [31:0] low_mem     = '0;
   logic [31:0] high_mem    = '0;
   logic [31:0] loader_ofs  = '0;
   logic [31:0] cmdline_ofs = '0;
   bit          fb_seen     = 1'b0;
   bit          mem_seen    = 1'b0;

   function automatic void clear_walk();
      walking = 1'b0;
      word_ofs = '0; struct_size = '0; tag_start = '0;
      cur_kind = '0; cur_bytes = '0; tags_total = '0;
      ent_size = '0; ent_pos = '0; pend_len = '0;
      map_count = '0; map_sum = '0; fb_addr = '0;
      fb_stride = '0; fb_cols = '0; fb_rows = '0; fb_bpp = '0;
      low_mem = '0; high_mem = '0; loader_ofs = '0; cmdline_ofs = '0;
      fb_seen = 1'b0; mem_seen = 1'b0;
   endfunction

   function automatic void push_record(record_id_type id, logic [63:0] value);
      summary_rec_type rec;
      rec.id      = id;
      rec.value   = value;
      rec.is_last = (id == REC_CMDLINE_OFF);
      expected_records.push_back(rec);
   endfunction

   // A finished walk always reports the same fifteen records, in id order.
   function automatic void emit_summary(walk_status_type status);
      push_record(REC_STATUS,      64'(status));
      push_record(REC_TAGS,        tags_total);
      push_record(REC_FB_PRESENT,  fb_seen);
      push_record(REC_FB_ADDR,     fb_addr);
      push_record(REC_PITCH,       fb_stride);
      push_record(REC_WIDTH,       fb_cols);
      push_record(REC_HEIGHT,      fb_rows);
      push_record(REC_BPP,         fb_bpp);
      push_record(REC_MEM_PRESENT, mem_seen);
      push_record(REC_MEM_LOWER,   low_mem);
      push_record(REC_MEM_UPPER,   high_mem);
      push_record(REC_MMAP_COUNT,  map_count);
      push_record(REC_MMAP_AVAIL,  map_sum);
      push_record(REC_LOADER_OFF,  loader_ofs);
      push_record(REC_CMDLINE_OFF, cmdline_ofs);
      walking = 1'b0;
   endfunction

   // True when the byte range lies entirely inside the current tag.
   function automatic bit tag_holds(logic [31:0] start, logic [31:0] len);
      return ({32'b0, start} + {32'b0, len}) <= {32'b0, cur_bytes};
   endfunction

   // Field capture for the body words of the current tag; k is the word index
   // within the tag, the tag header being word zero.
   function automatic void capture_field(logic [31:0] k, logic [63:0] w);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = w[31:0];
      hi = w[63:32];
      case (cur_kind)
         TAG_BASIC_MEM: begin
            if (k == 1) begin
               if (tag_holds(8, 4)) low_mem = lo;
               if (tag_holds(12, 4)) high_mem = hi;
            end
         end
         TAG_FRAMEBUFFER: begin
            if (k == 1 && tag_holds(8, 8)) fb_addr = w;
            if (k == 2) begin
               if (tag_holds(16, 4)) fb_stride = lo;
               if (tag_holds(20, 4)) fb_cols = hi;
            end
            if (k == 3) begin
               if (tag_holds(24, 4)) fb_rows = lo;
               if (tag_holds(28, 1)) fb_bpp = hi[7:0];
            end
         end
         TAG_MMAP: begin
            if (k == 1) begin
               ent_size = '0;
               if (tag_holds(8, 4) && lo[2:0] == 3'd0 && lo >= MIN_ENTRY_BYTES)
                  ent_size = lo;
               ent_pos  = '0;
               pend_len = '0;
            end else if (ent_size != 0) begin
               // Entry words: base, length, then type in the low half.
               if (ent_pos == 1) pend_len = w;
               if (ent_pos == 2 && lo != MMAP_AVAILABLE) pend_len = '0;
               if (ent_pos == (ent_size >> 3) - 1) begin
                  if ((({32'b0, k}) << 3) + 64'd8 <= {32'b0, cur_bytes}) begin
                     map_count++;
                     map_sum += pend_len;
                  end
                  ent_pos  = '0;
                  pend_len = '0;
               end else begin
                  ent_pos++;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Advances the predicted walk by one accepted structure word.
   function automatic void walk_word(logic first, logic [63:0] w);
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] k;
      logic [63:0] nxt;
      logic [63:0] rounded;
      lo = w[31:0];
      hi = w[63:32];
      if (first) begin
         clear_walk();
         struct_size = lo;
         word_ofs    = 32'd8;
         tag_start   = 32'd8;
         walking     = 1'b1;
         if (lo <= 32'd8) emit_summary(STATUS_SIZE_REACHED);
         return;
      end
      if (!walking) return;

      k = (word_ofs - tag_start) >> 3;
      if (k == 0) begin
         cur_kind  = lo;
         cur_bytes = hi;
         tags_total++;
         if (lo == TAG_END) begin
            emit_summary(STATUS_END_TAG);
            return;
         end
         if (hi < MIN_TAG_BYTES) begin
            emit_summary(STATUS_MALFORMED);
            return;
         end
         ent_size = '0;
         ent_pos  = '0;
         pend_len = '0;
         case (lo)
            TAG_CMDLINE:     cmdline_ofs = tag_start + 32'd8;
            TAG_LOADER_NAME: loader_ofs  = tag_start + 32'd8;
            TAG_BASIC_MEM: begin
               mem_seen = 1'b1;
               low_mem  = '0;
               high_mem = '0;
            end
            TAG_MMAP: begin
               map_count = '0;
               map_sum   = '0;
            end
            TAG_FRAMEBUFFER: begin
               fb_seen   = 1'b1;
               fb_addr   = '0;
               fb_stride = '0;
               fb_cols   = '0;
               fb_rows   = '0;
               fb_bpp    = '0;
            end
            default: ;
         endcase
      end else begin
         capture_field(k, w);
      end

      nxt = {32'b0, word_ofs} + 64'd8;
      if (nxt > 64'hFFFF_FFFF) begin
         emit_summary(STATUS_SIZE_REACHED);
         return;
      end
      rounded = ({32'b0, cur_bytes} + 64'd7) & ~64'd7;
      if (nxt - {32'b0, tag_start} >= rounded) begin
         if (nxt >= {32'b0, struct_size}) begin
            emit_summary(STATUS_SIZE_REACHED);
            return;
         end
         tag_start = nxt[31:0];
      end
      word_ofs = nxt[31:0];
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction. Structures are assembled as byte images, tag by
   // tag, and then cut into little-endian words behind a header word.
   // ------------------------------------------------------------------------
   function automatic void push_word(bit first, logic [63:0] data, bit counts = 1'b1,
                                     bit hold_back = 1'b0);
      word_item_type item;
      item.first     = first;
      item.data      = data;
      item.hold_back = hold_back;
      words_to_send.push_back(item);
      if (counts) words_counted++;
   endfunction

   function automatic void image_put(logic [63:0] v, int unsigned n);
      for (int unsigned i = 0; i < n; i++) image_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic void body_put(logic [63:0] v, int unsigned n);
      for (int unsigned i = 0; i < n; i++) tag_body.push_back(v[8*i +: 8]);
   endfunction

   // Appends a tag of the given size. The prepared body is used first, the
   // rest of the tag and the padding to eight bytes are random filler.
   function automatic void add_tag(logic [31:0] kind, logic [31:0] size);
      image_put({size, kind}, 8);
      for (int unsigned i = 8; i < size; i++)
         image_bytes.push_back((i - 8 < tag_body.size()) ? tag_body[i - 8] : 8'($urandom));
      while (image_bytes.size() % 8 != 0) image_bytes.push_back(8'($urandom));
      tag_body.delete();
   endfunction

   // Memory map tag: mostly valid entry sizes, sometimes a size that must
   // disable decoding, and sometimes a tag that cuts the last entry short.
   function automatic void add_mmap_tag();
      int unsigned r;
      int unsigned esz;
      int unsigned layout;
      int unsigned n;
      int unsigned full;
      int unsigned sz;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2, 3: esz = 24;
         4, 5, 6:    esz = 32;
         7:          esz = 48;
         8:          esz = 8 * $urandom_range(0, 2);
         default:    esz = $urandom | 1;
      endcase
      layout = (esz >= 24 && esz % 8 == 0) ? esz : 24;
      n = $urandom_range(0, 4);
      body_put(esz, 4);
      body_put($urandom, 4);
      repeat (n) begin
         body_put({$urandom, $urandom}, 8);
         body_put(($urandom_range(0, 2) == 0) ? {$urandom, $urandom}
                                              : 64'($urandom_range(0, 65535)), 8);
         body_put(($urandom_range(0, 9) < 7) ? MMAP_AVAILABLE : 32'($urandom), 4);
         body_put($urandom, 4);
         repeat (layout - 24) body_put($urandom, 1);
      end
      full = 16 + n * layout;
      r = $urandom_range(0, 9);
      if (r < 7 || n == 0) sz = full;
      else if (r < 9) sz = full - $urandom_range(1, layout - 1);
      else sz = $urandom_range(8, 15);
      add_tag(TAG_MMAP, sz);
   endfunction

   function automatic void add_random_tag();
      int unsigned pick;
      pick = $urandom_range(0, 11);
      case (pick)
         0: add_tag(TAG_CMDLINE, 8 + $urandom_range(0, 24));
         1: add_tag(TAG_LOADER_NAME, 8 + $urandom_range(0, 24));
         2, 3: add_tag(TAG_BASIC_MEM,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : 16);
         4, 5, 6: add_mmap_tag();
         7, 8: add_tag(TAG_FRAMEBUFFER,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : 32);
         9, 10: add_tag($urandom_range(3, 40), $urandom_range(8, 40));
         default: begin
            if ($urandom_range(0, 3) == 0) begin
               // A tag far larger than the structure keeps the walk busy until
               // the next header word restarts it.
               image_put({1'b1, 31'($urandom), 32'($urandom_range(9, 40))}, 8);
               image_put({$urandom, $urandom}, 8);
            end else begin
               add_tag($urandom, $urandom_range(8, 24));
            end
         end
      endcase
   endfunction

   // Sends the assembled image behind a header that declares total bytes.
   function automatic void queue_structure(logic [31:0] total);
      logic [63:0] wd;
      push_word(1'b1, {32'($urandom), total}, 1'b1, (structures_made % 15) == 7);
      structures_made++;
      for (int i = 0; i < image_bytes.size(); i += 8) begin
         for (int j = 0; j < 8; j++) wd[8*j +: 8] = image_bytes[i + j];
         push_word(1'b0, wd);
      end
      image_bytes.delete();
   endfunction

   function automatic void queue_random_structure();
      int unsigned mode;
      int unsigned pick;
      logic [31:0] span;
      logic [31:0] total;
      mode = $urandom_range(0, 99);
      if (mode < 6) begin
         // Declared size too small to hold any tag.
         queue_structure($urandom_range(0, 8));
         return;
      end
      if (mode < 11) begin
         // Stray words between structures.
         repeat ($urandom_range(1, 3)) push_word(1'b0, {$urandom, $urandom});
         return;
      end
      repeat ($urandom_range(1, 5)) add_random_tag();
      if (mode < 20) begin
         add_tag($urandom, $urandom_range(0, 7));
      end else if (mode < 85) begin
         // An end tag ends the walk whatever size it claims.
         image_put({($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'd8, TAG_END}, 8);
      end
      span = 8 + image_bytes.size();
      pick = $urandom_range(0, 9);
      if (pick < 6) total = span;
      else if (pick < 8) total = $urandom_range(9, span);
      else if (pick == 8) total = span + $urandom_range(1, 64);
      else total = $urandom;
      if (mode >= 92) begin
         // Cut the structure short; the next header abandons this walk.
         repeat (8 * $urandom_range(1, image_bytes.size() / 8))
            void'(image_bytes.pop_back());
      end
      queue_structure(total);
   endfunction

   // Each side waits a random number of cycles per transaction, and now and
   // then switches into or out of a stretch with no waiting at all.
   function automatic int unsigned draw_gap(inout bit quiet);
      if ($urandom_range(0, 29) == 0) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 13);
   endfunction

   // ------------------------------------------------------------------------
   // Word driver. Changes its outputs at the falling edge. A word stays on the
   // channel until the monitor has seen it accepted at a rising edge; then the
   // driver either idles for the drawn number of cycles or offers the next one.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : word_driver
      word_item_type item;
      if (!reset && !(word_valid && !word_taken)) begin
         if (word_valid) word_wait = draw_gap(word_quiet);
         if (word_wait > 0) begin
            word_wait--;
            word_valid <= 1'b0;
         end else if (words_to_send.size() != 0 &&
                      !(words_to_send[0].hold_back && expected_records.size() != 0)) begin
            item = words_to_send.pop_front();
            word_valid <= 1'b1;
            word_first <= item.first;
            word_data  <= item.data;
         end else begin
            word_valid <= 1'b0;
         end
      end
   end

   // Record receiver: after every accepted record it may stall for a while.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) rsp_wait = draw_gap(rsp_quiet);
         if (rsp_wait > 0) begin
            rsp_wait--;
            record_ready <= 1'b0;
         end else begin
            record_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. At each rising edge it checks an accepted record against the
   // oldest prediction and then feeds an accepted word to the predictor.
   // Records are always accepted at a later edge than the word that caused them, so
   // checking first never misses a prediction from the same edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : record_monitor
      summary_rec_type want;
      if (reset) begin
         word_taken <= 1'b0;
         rsp_taken  <= 1'b0;
      end else begin
         word_taken <= req_bus.valid && req_bus.ready;
         rsp_taken  <= rsp_bus.valid && rsp_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_records.size() == 0) begin
               $error("unexpected record: id %0d value %h last %b",
                      rsp_bus.record_id, rsp_bus.record_value, rsp_bus.last_record);
               error_count++;
            end else begin
               want = expected_records.pop_front();
               if (rsp_bus.record_id !== want.id) begin
                  $error("record_id: expected %0d, got %0d", want.id, rsp_bus.record_id);
                  error_count++;
               end
               if (rsp_bus.record_value !== want.value) begin
                  $error("record_value (id %0d): expected %h, got %h",
                         want.id, want.value, rsp_bus.record_value);
                  error_count++;
               end
               if (rsp_bus.last_record !== want.is_last) begin
                  $error("last_record (id %0d): expected %b, got %b",
                         want.id, want.is_last, rsp_bus.last_record);
                  error_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) walk_word(req_bus.first_word, req_bus.info_word);
      end
   end

   // Hard stop in case the block hangs or stops sending records.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of test.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned random_target;

      // Directed part. A stray word before any header is ignored.
      push_word(1'b0, '1);
      // Declared sizes of zero and exactly eight end the walk at the header.
      push_word(1'b1, {32'hFFFF_FFFF, 32'd0});
      push_word(1'b1, {32'h0, 32'd8});
      // Largest declared size, ended at once by an end tag.
      push_word(1'b1, {32'h0, 32'hFFFF_FFFF});
      push_word(1'b0, {32'd8, TAG_END});
      // A tag of seven bytes is malformed and still counted.
      push_word(1'b1, {32'h0, 32'h100});
      push_word(1'b0, {32'd7, 32'hFFFF_FFFF});
      // A walk abandoned mid-tag by a new header, which then finds a basic
      // memory tag too short to carry the upper size.
      push_word(1'b1, {32'h0, 32'h100});
      push_word(1'b0, {32'd16, TAG_BASIC_MEM});
      push_word(1'b1, {32'h0, 32'd24});
      push_word(1'b0, {32'd12, TAG_BASIC_MEM});
      push_word(1'b0, '1);
      // Framebuffer with every field at its maximum, then an end tag. The
      // header waits until the earlier summaries have drained.
      push_word(1'b1, {32'h0, 32'd48}, 1'b1, 1'b1);
      push_word(1'b0, {32'd32, TAG_FRAMEBUFFER});
      push_word(1'b0, '1);
      push_word(1'b0, '1);
      push_word(1'b0, '1);
      push_word(1'b0, {32'd8, TAG_END});
      // Loader name and a one-entry memory map; the walk ends on total size.
      push_word(1'b1, {32'hFFFF_FFFF, 32'd64});
      push_word(1'b0, {32'd9, TAG_LOADER_NAME});
      push_word(1'b0, '0);
      push_word(1'b0, {32'd40, TAG_MMAP});
      push_word(1'b0, {32'd0, 32'd24});
      push_word(1'b0, '1);
      push_word(1'b0, '1);
      push_word(1'b0, {32'h0, MMAP_AVAILABLE});

      // Random part: mostly well-formed structures with random content, up to
      // the overall word budget.
      random_target = RANDOM_WORDS;
      while (words_counted < random_target) queue_random_structure();

      // Reset is held, then released at a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_to_send.size() != 0 || word_valid) @(posedge clock);
      while (expected_records.size() != 0) @(posedge clock);
      // Let any late, unpredicted record show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/bitp_pkg.sv
rtl/bitp_req_if.sv
rtl/bitp_rsp_if.sv
rtl/bitp_walker.sv
rtl/bitp_summary.sv
rtl/boot_info_tag_parser_top.sv
rtl/bitp_checker.sv
tb/tb_top.sv
